// ===== src/crc_bit_serial_gen_check_assert.svh =====
// Assertion macros shared by the CRC block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CRC_BIT_SERIAL_GEN_CHECK_ASSERT_SVH
`define CRC_BIT_SERIAL_GEN_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/crc_bsgc_pkg.sv =====
package crc_bsgc_pkg;

  localparam int MAX_DEGREE_DEF = 32;
  localparam int POLY_W         = 32;
  localparam int DEG_W          = 6;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 4;
  localparam int REG_IDX_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_GEN_POLY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEGREE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd2;

  localparam logic MODE_GEN = 1'b0;
  localparam logic MODE_CHK = 1'b1;

  localparam logic [POLY_W-1:0] GEN_POLY_RST = 32'h0000_1021;
  localparam logic [DEG_W-1:0]  DEGREE_RST   = 6'd16;
  localparam logic              MODE_RST     = MODE_GEN;

  typedef struct packed {
    logic [POLY_W-1:0] gen_poly;
    logic [DEG_W-1:0]  degree;
    logic              mode;
  } cfg_t;

  // Control that the top level broadcasts to every cell of the row.
  typedef struct packed {
    logic adv;    // an input bit is accepted
    logic clr;    // that bit ends the message
    logic fb;     // feedback bit of this step
    logic load;   // capture the new remainder for emission
    logic shift;  // one remainder bit leaves the block
  } cell_ctl_t;

endpackage

// ===== src/crc_bsgc_if.sv =====
interface crc_bsgc_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic end_of_message;

  modport source (output valid, output data_bit, output end_of_message, input ready);
  modport sink (input valid, input data_bit, input end_of_message, output ready);
endinterface

interface crc_bsgc_out_if;
  logic valid;
  logic ready;
  logic rem_bit;
  logic final_result;
  logic crc_error;

  modport source (output valid, output rem_bit, output final_result, output crc_error,
                  input ready);
  modport sink (input valid, input rem_bit, input final_result, input crc_error,
                output ready);
endinterface

// ===== src/crc_bit_serial_gen_check.sv =====
// Bit-serial CRC generator and checker with a programmable generator of degree 1 to
// 32 (capped by MAX_DEGREE). One message bit is taken per clock, except that an
// end-of-message bit may wait for the output. In generate mode the end-of-message
// bit starts the emission of the remainder, one bit per cycle while the output is
// ready, most significant first, so a message produces degree results; in check
// mode it produces one result that flags a nonzero remainder. Bits without the end
// flag are always taken, also while a remainder drains; an end-of-message bit
// waits until no result of the previous message is pending or the last one leaves
// in that cycle. The remainder lives in a row of cells, one bit per cell, that also
// holds the outgoing remainder. The user must write configuration through the APB
// port only while the block is idle; the block itself does not enforce this.
module crc_bit_serial_gen_check #(
  parameter int MAX_DEGREE = crc_bsgc_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  crc_bsgc_in_if.sink                         in_ch,
  crc_bsgc_out_if.source                      out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [crc_bsgc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [crc_bsgc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [crc_bsgc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import crc_bsgc_pkg::*;
  `include "crc_bit_serial_gen_check_assert.svh"

  localparam int NCELL = (MAX_DEGREE < POLY_W) ? MAX_DEGREE : POLY_W;
  localparam int CW    = $clog2(NCELL + 1);

  cfg_t            cfg;
  cell_ctl_t       ctl;
  logic [DEG_W-1:0] deg_eff;
  logic [NCELL-1:0] mask_vec;
  logic [NCELL-1:0] top_vec;
  logic [NCELL-1:0] run_q;
  logic [NCELL-1:0] run_m;
  logic [NCELL-1:0] run_new;
  logic [NCELL-1:0] emit_q;
  logic [NCELL-1:0] prev_run;
  logic [NCELL-1:0] prev_emit;
  logic             top_bit;
  logic             in_acc;
  logic             out_acc;
  logic             end_acc;
  logic             emit_free;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             chk_r, chk_nxt;
  logic             err_r, err_nxt;

  crc_bsgc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Degree zero acts as one, and large values saturate at the row length.
  always_comb begin
    if (cfg.degree == '0) begin
      deg_eff = DEG_W'(1);
    end else if (cfg.degree > DEG_W'(NCELL)) begin
      deg_eff = DEG_W'(NCELL);
    end else begin
      deg_eff = cfg.degree;
    end
  end

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_ch.valid & out_ch.ready;
  assign end_acc = in_acc & in_ch.end_of_message;

  assign run_m   = run_q & mask_vec;
  assign top_bit = |(run_m & top_vec);

  always_comb begin
    ctl.adv   = in_acc;
    ctl.clr   = in_ch.end_of_message;
    ctl.fb    = (cfg.mode == MODE_CHK) ? top_bit : (top_bit ^ in_ch.data_bit);
    ctl.load  = end_acc & (cfg.mode == MODE_GEN);
    ctl.shift = out_acc;
  end

  genvar i;
  generate
    for (i = 0; i < NCELL; i++) begin : g_cell
      assign mask_vec[i] = (deg_eff > DEG_W'(i));
      assign top_vec[i]  = (deg_eff == DEG_W'(i + 1));
      if (i == 0) begin : g_head
        // In check mode the received bit enters at the low end of the row.
        assign prev_run[i]  = (cfg.mode == MODE_CHK) ? in_ch.data_bit : 1'b0;
        assign prev_emit[i] = 1'b0;
      end else begin : g_body
        assign prev_run[i]  = run_m[i-1];
        assign prev_emit[i] = emit_q[i-1];
      end
      crc_bsgc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .mask_bit  (mask_vec[i]),
        .poly_bit  (cfg.gen_poly[i]),
        .prev_run  (prev_run[i]),
        .prev_emit (prev_emit[i]),
        .run_q     (run_q[i]),
        .run_new   (run_new[i]),
        .emit_q    (emit_q[i])
      );
    end
  endgenerate

  // A new end-of-message item may enter once the pending results fit in this cycle.
  assign emit_free   = (cnt_r == '0) | ((cnt_r == CW'(1)) & out_ch.ready);
  assign in_ch.ready = emit_free | ~in_ch.end_of_message;

  always_comb begin
    cnt_nxt = cnt_r;
    chk_nxt = chk_r;
    err_nxt = err_r;
    if (end_acc) begin
      cnt_nxt = (cfg.mode == MODE_CHK) ? CW'(1) : CW'(deg_eff);
      chk_nxt = cfg.mode;
      err_nxt = (cfg.mode == MODE_CHK) & (|run_new);
    end else if (out_acc) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    err_r <= err_nxt;
  end

  // The emission row shifts up, so the next bit is always at the top position.
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.rem_bit      = ~chk_r & (|(emit_q & top_vec));
  assign out_ch.final_result = (cnt_r == CW'(1));
  assign out_ch.crc_error    = chk_r & err_r;

  `CRC_ASSERT_SAME(a_end_no_overrun, end_acc, (cnt_r <= CW'(1)),
                   "end of message taken while earlier results were pending")
  `CRC_ASSERT_NEXT(a_rem_cleared, end_acc, (run_q == '0),
                   "running remainder not cleared after end of message")
  `CRC_ASSERT_SAME(a_chk_single, (out_ch.valid & chk_r), (cnt_r == CW'(1)),
                   "check result is not a single item")
  `CRC_ASSERT_NEXT(a_cnt_step, (out_acc & ~end_acc), (cnt_r == $past(cnt_r) - CW'(1)),
                   "result count did not step down on output")

endmodule

// ===== src/crc_bsgc_cfg.sv =====
module crc_bsgc_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [crc_bsgc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [crc_bsgc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [crc_bsgc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready,
  output crc_bsgc_pkg::cfg_t                     cfg
);
  import crc_bsgc_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen_poly <= GEN_POLY_RST;
      cfg_r.degree   <= DEGREE_RST;
      cfg_r.mode     <= MODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GEN_POLY: cfg_r.gen_poly <= cfg_pwdata[POLY_W-1:0];
        REG_DEGREE:   cfg_r.degree   <= cfg_pwdata[DEG_W-1:0];
        REG_MODE:     cfg_r.mode     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (reg_idx)
      REG_GEN_POLY: cfg_prdata = CFG_DATA_W'(cfg_r.gen_poly);
      REG_DEGREE:   cfg_prdata = CFG_DATA_W'(cfg_r.degree);
      REG_MODE:     cfg_prdata = CFG_DATA_W'(cfg_r.mode);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/crc_bsgc_cell.sv =====
module crc_bsgc_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  crc_bsgc_pkg::cell_ctl_t ctl,
  input  logic                    mask_bit,
  input  logic                    poly_bit,
  input  logic                    prev_run,
  input  logic                    prev_emit,
  output logic                    run_q,
  output logic                    run_new,
  output logic                    emit_q
);
  import crc_bsgc_pkg::*;

  logic run_r;
  logic emit_r;

  // One step of the division for this remainder bit.
  assign run_new = mask_bit & (prev_run ^ (ctl.fb & poly_bit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (ctl.adv) begin
      run_r <= ctl.clr ? 1'b0 : run_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      emit_r <= run_new;
    end else if (ctl.shift) begin
      emit_r <= prev_emit;
    end
  end

  assign run_q  = run_r;
  assign emit_q = emit_r;

endmodule
